// ===== hdl/oca_pkg.sv =====
// oca_pkg: shared types, constants and word conversion for the 18-bit ones' complement alu
// used by every module under hdl; no dependencies of its own
`default_nettype none

package oca_pkg;

	localparam int WORD_W      = 18;
	localparam int MAG_W       = WORD_W - 1;
	localparam int SUM_W       = WORD_W + 1;
	localparam int SHIFT_W     = 5;
	localparam int SHIFT_LIMIT = WORD_W;
	localparam int DIV_STEPS   = 6;

	typedef enum logic [3:0] {
		ACT_OR     = 4'd0,
		ACT_XOR    = 4'd1,
		ACT_AND    = 4'd2,
		ACT_LSHIFT = 4'd3,
		ACT_RSHIFT = 4'd4,
		ACT_CMPL   = 4'd5,
		ACT_PLUS   = 4'd6,
		ACT_MINUS  = 4'd7,
		ACT_MUL    = 4'd8,
		ACT_DIV    = 4'd9,
		ACT_MOD    = 4'd10,
		ACT_NEGATE = 4'd11
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DIV_ZERO = 2'd1,
		ST_BAD_OP   = 2'd2
	} status_t;

	// one beat as it travels down the pipeline
	typedef struct packed {
		action_t           op;
		logic [WORD_W-1:0] early;
		logic              sx;
		logic              sy;
		logic [MAG_W-1:0]  mx;
		logic [MAG_W-1:0]  my;
		logic [SUM_W-1:0]  xs;
		logic [SUM_W-1:0]  ys;
		logic [SUM_W-1:0]  sum;
		logic [WORD_W-1:0] prod;
		logic [MAG_W-1:0]  rem;
		logic [WORD_W-1:0] quo;
	} pipe_t;

	// sign and magnitude back to a ones' complement word, negative zero folded to zero
	function automatic logic [WORD_W-1:0] oc_word(input logic neg, input logic [WORD_W-1:0] mag);
		logic [WORD_W-1:0] w;
		w = neg ? ~mag : mag;
		if (&w) begin
			w = '0;
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/oca_front.sv =====
// oca_front: operand decode, bitwise and shift results, signed forms and divider seed
// depends on oca_pkg
`default_nettype none

module oca_front
	import oca_pkg::*;
(
	input  wire logic [3:0]        action,
	input  wire logic [WORD_W-1:0] left_operand,
	input  wire logic [WORD_W-1:0] right_operand,
	output pipe_t                  entry
);

	logic [SHIFT_W-1:0] sh;
	logic               too_far;

	assign sh      = right_operand[SHIFT_W-1:0];
	assign too_far = (|right_operand[WORD_W-1:SHIFT_W]) || (sh >= SHIFT_W'(SHIFT_LIMIT));

	always_comb begin
		entry    = '0;
		entry.op = action_t'(action);
		entry.sx = left_operand[WORD_W-1];
		entry.sy = right_operand[WORD_W-1];
		entry.mx = left_operand[WORD_W-1] ? ~left_operand[MAG_W-1:0] : left_operand[MAG_W-1:0];
		entry.my = right_operand[WORD_W-1] ? ~right_operand[MAG_W-1:0]
			: right_operand[MAG_W-1:0];
		// negative word is its sign extension plus one
		entry.xs = {left_operand[WORD_W-1], left_operand} + SUM_W'(left_operand[WORD_W-1]);
		entry.ys = {right_operand[WORD_W-1], right_operand} + SUM_W'(right_operand[WORD_W-1]);
		entry.rem = '0;
		entry.quo = {1'b0, entry.mx};
		case (action_t'(action))
			ACT_OR: begin
				entry.early = left_operand | right_operand;
			end
			ACT_XOR: begin
				entry.early = left_operand ^ right_operand;
			end
			ACT_AND: begin
				entry.early = left_operand & right_operand;
			end
			ACT_LSHIFT: begin
				entry.early = too_far ? '0 : (left_operand << sh);
			end
			ACT_RSHIFT: begin
				entry.early = too_far ? '0 : (left_operand >> sh);
			end
			ACT_CMPL: begin
				entry.early = ~left_operand;
			end
			ACT_NEGATE: begin
				entry.early = oc_word(1'b1, left_operand);
			end
			default: begin
				entry.early = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/oca_div_stage.sv =====
// oca_div_stage: a slice of restoring division steps on magnitudes
// depends on oca_pkg; one instance sits in front of each divider pipeline register
`default_nettype none

module oca_div_stage
	import oca_pkg::*;
(
	input  wire logic [MAG_W-1:0]  rem_in,
	input  wire logic [WORD_W-1:0] quo_in,
	input  wire logic [MAG_W-1:0]  dvs,
	output logic      [MAG_W-1:0]  rem_out,
	output logic      [WORD_W-1:0] quo_out
);

	always_comb begin
		logic [MAG_W:0]    t;
		logic              ge;
		logic [MAG_W-1:0]  r;
		logic [WORD_W-1:0] q;
		r = rem_in;
		q = quo_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t  = {r, q[WORD_W-1]};
			ge = (t >= {1'b0, dvs});
			if (ge) begin
				t = t - {1'b0, dvs};
			end
			q = {q[WORD_W-2:0], ge};
			r = t[MAG_W-1:0];
		end
		rem_out = r;
		quo_out = q;
	end

endmodule

`default_nettype wire

// ===== hdl/oca_format.sv =====
// oca_format: picks the final ones' complement word and status for a beat
// depends on oca_pkg
`default_nettype none

module oca_format
	import oca_pkg::*;
(
	input  wire pipe_t             beat,
	output logic      [WORD_W-1:0] word,
	output status_t                st
);

	logic              div_zero;
	logic [SUM_W-1:0]  sum_m1;
	logic [WORD_W-1:0] sum_word;

	assign div_zero = (beat.my == '0);
	assign sum_m1   = beat.sum - SUM_W'(1);

	always_comb begin
		sum_word = beat.sum[SUM_W-1] ? sum_m1[WORD_W-1:0] : beat.sum[WORD_W-1:0];
		if (&sum_word) begin
			sum_word = '0;
		end
	end

	always_comb begin
		word = '0;
		st   = ST_OK;
		case (beat.op)
			ACT_OR, ACT_XOR, ACT_AND, ACT_LSHIFT, ACT_RSHIFT, ACT_CMPL, ACT_NEGATE: begin
				word = beat.early;
			end
			ACT_PLUS, ACT_MINUS: begin
				word = sum_word;
			end
			ACT_MUL: begin
				word = oc_word(beat.sx ^ beat.sy, beat.prod);
			end
			ACT_DIV: begin
				if (div_zero) begin
					st = ST_DIV_ZERO;
				end else begin
					word = oc_word(beat.sx ^ beat.sy, beat.quo);
				end
			end
			ACT_MOD: begin
				if (div_zero) begin
					st = ST_DIV_ZERO;
				end else begin
					word = oc_word(beat.sx, {1'b0, beat.rem});
				end
			end
			default: begin
				st = ST_BAD_OP;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/ones_complement_18bit_alu.sv =====
// ones_complement_18bit_alu: five-stage pipelined 18-bit ones' complement alu
// an accepted beat goes into stage 1, then through stages 2 to 4 into the output register
// throughput: one beat per cycle; the divider is split over three stages of six steps
// a stall holds occupied stages back to the first empty one, and empty stages still fill
// reset clears the stage valid bits only; payload registers are not reset
// depends on oca_pkg, oca_front, oca_div_stage, oca_format
`default_nettype none

module ones_complement_18bit_alu
	import oca_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [3:0]        action,
	input  wire logic [WORD_W-1:0] left_operand,
	input  wire logic [WORD_W-1:0] right_operand,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [WORD_W-1:0] result,
	output logic      [1:0]        status
);

	pipe_t entry;
	pipe_t p_s1, p_s2, p_s3, p_s4;
	pipe_t nxt_s2, nxt_s3, nxt_s4;
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic  adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic  [WORD_W-1:0] result_s5, fmt_word;
	status_t            status_s5, fmt_st;
	logic  [MAG_W-1:0]  rem_s2, rem_s3, rem_s4;
	logic  [WORD_W-1:0] quo_s2, quo_s3, quo_s4;
	logic  [2*MAG_W-1:0] prod_full;

	assign adv_s5 = !vld_s5 || !rsp_stall;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign req_stall = !adv_s1;

	oca_front u_front (
		.action        (action),
		.left_operand  (left_operand),
		.right_operand (right_operand),
		.entry         (entry)
	);

	oca_div_stage u_div_s2 (
		.rem_in  (p_s1.rem),
		.quo_in  (p_s1.quo),
		.dvs     (p_s1.my),
		.rem_out (rem_s2),
		.quo_out (quo_s2)
	);

	oca_div_stage u_div_s3 (
		.rem_in  (p_s2.rem),
		.quo_in  (p_s2.quo),
		.dvs     (p_s2.my),
		.rem_out (rem_s3),
		.quo_out (quo_s3)
	);

	oca_div_stage u_div_s4 (
		.rem_in  (p_s3.rem),
		.quo_in  (p_s3.quo),
		.dvs     (p_s3.my),
		.rem_out (rem_s4),
		.quo_out (quo_s4)
	);

	oca_format u_format (
		.beat (p_s4),
		.word (fmt_word),
		.st   (fmt_st)
	);

	assign prod_full = p_s1.mx * p_s1.my;

	always_comb begin
		nxt_s2      = p_s1;
		nxt_s2.sum  = (p_s1.op == ACT_MINUS) ? (p_s1.xs - p_s1.ys) : (p_s1.xs + p_s1.ys);
		nxt_s2.prod = prod_full[WORD_W-1:0];
		nxt_s2.rem  = rem_s2;
		nxt_s2.quo  = quo_s2;
	end

	always_comb begin
		nxt_s3     = p_s2;
		nxt_s3.rem = rem_s3;
		nxt_s3.quo = quo_s3;
	end

	always_comb begin
		nxt_s4     = p_s3;
		nxt_s4.rem = rem_s4;
		nxt_s4.quo = quo_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= req_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_s3) begin
				vld_s3 <= vld_s2;
			end
			if (adv_s4) begin
				vld_s4 <= vld_s3;
			end
			if (adv_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			p_s1 <= entry;
		end
		if (adv_s2) begin
			p_s2 <= nxt_s2;
		end
		if (adv_s3) begin
			p_s3 <= nxt_s3;
		end
		if (adv_s4) begin
			p_s4 <= nxt_s4;
		end
		if (adv_s5) begin
			result_s5 <= fmt_word;
			status_s5 <= fmt_st;
		end
	end

	assign rsp_valid = vld_s5;
	assign result    = result_s5;
	assign status    = status_s5;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench: self-checking bench for ones_complement_18bit_alu, a directed set then random beats
// with random gaps, stalls, one long output hold and drain pauses; every result is predicted here
// depends on oca_pkg (word widths, action and status codes) and the alu top level under hdl
module testbench;
	import oca_pkg::*;

	localparam int IDLE_MAX    = 19;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_AT     = 350;
	localparam int HOLD_CYCLES = 150;
	localparam int RANDOM_BEATS = 600;
	localparam int TAIL_CYCLES = 12;

	localparam logic [3:0]        ACTION_MAX = '1;
	localparam logic [WORD_W-1:0] NEG_ZERO   = '1;
	localparam logic [WORD_W-1:0] MAX_POS    = {1'b0, {MAG_W{1'b1}}};
	localparam logic [WORD_W-1:0] MAX_NEG    = {1'b1, {MAG_W{1'b0}}};

	typedef struct {
		logic [3:0]        op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		int                gap;
		bit                drain;
	} alu_beat_t;

	typedef struct {
		logic [3:0]        op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] result;
		status_t           status;
	} alu_answer_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              req_valid = 0;
	logic              req_stall;
	logic [3:0]        action = '0;
	logic [WORD_W-1:0] left_operand = '0;
	logic [WORD_W-1:0] right_operand = '0;
	logic              rsp_valid;
	logic              rsp_stall = 0;
	logic [WORD_W-1:0] result;
	logic [1:0]        status;

	alu_beat_t   beat_q[$];
	alu_answer_t answer_q[$];
	alu_beat_t   cur_beat;
	bit          holding = 0;
	bit          sender_idles = 1;
	bit          req_took = 0;
	bit          rsp_took = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          beats_sent = 0;
	int          results_seen = 0;
	int          div_zero_seen = 0;
	int          bad_op_seen = 0;
	int          errors = 0;
	int          idle_cycles = 0;

	ones_complement_18bit_alu DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.left_operand (left_operand),
		.right_operand(right_operand),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.result       (result),
		.status       (status)
	);

	always #2 clk = ~clk;

	function automatic longint oc_value(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] m;
		m = ~w;
		if (w[WORD_W-1]) begin
			return -longint'(m);
		end
		return longint'(w);
	endfunction

	function automatic logic [WORD_W-1:0] oc_encode(input longint v);
		logic [WORD_W-1:0] w;
		w = WORD_W'((v < 0) ? v - 1 : v);
		if (&w) begin
			w = '0;
		end
		return w;
	endfunction

	function automatic alu_answer_t predict_alu(input logic [3:0] op, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		alu_answer_t ans;
		longint x;
		longint y;
		x = oc_value(a);
		y = oc_value(b);
		ans.op = op;
		ans.a = a;
		ans.b = b;
		ans.result = '0;
		ans.status = ST_OK;
		case (op)
			ACT_OR:     ans.result = a | b;
			ACT_XOR:    ans.result = a ^ b;
			ACT_AND:    ans.result = a & b;
			ACT_LSHIFT: ans.result = (b >= SHIFT_LIMIT) ? '0 : a << b;
			ACT_RSHIFT: ans.result = (b >= SHIFT_LIMIT) ? '0 : a >> b;
			ACT_CMPL:   ans.result = ~a;
			ACT_PLUS:   ans.result = oc_encode(x + y);
			ACT_MINUS:  ans.result = oc_encode(x - y);
			ACT_MUL:    ans.result = oc_encode(x * y);
			ACT_DIV, ACT_MOD: begin
				if (y == 0) begin
					ans.status = ST_DIV_ZERO;
				end else begin
					ans.result = oc_encode(op == ACT_DIV ? x / y : x % y);
				end
			end
			ACT_NEGATE: begin
				ans.result = ~a;
				if (&ans.result) begin
					ans.result = '0;
				end
			end
			default:    ans.status = ST_BAD_OP;
		endcase
		return ans;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		w = WORD_W'($urandom);
		case ($urandom_range(0, 4))
			0: w = WORD_W'($urandom_range(0, 40));
			1: w = WORD_W'(~$urandom_range(0, 40));
			2: begin
				case ($urandom_range(0, 3))
					0: w = '0;
					1: w = NEG_ZERO;
					2: w = MAX_POS;
					default: w = MAX_NEG;
				endcase
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic add_beat(input logic [3:0] op, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input bit drain = 0);
		alu_beat_t bt;
		bt.op = op;
		bt.a = a;
		bt.b = b;
		bt.gap = sender_idles ? $urandom_range(0, IDLE_MAX) : 0;
		bt.drain = drain;
		beat_q.push_back(bt);
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		$display("error at %0t: %s", $time, what);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_took)) begin
			if (!holding && beat_q.size() != 0) begin
				cur_beat = beat_q.pop_front();
				holding = 1;
				gap_left = cur_beat.gap;
			end
			if (!holding) begin
				req_valid <= 0;
			end else if (gap_left > 0) begin
				gap_left--;
				req_valid <= 0;
			end else if (cur_beat.drain && answer_q.size() != 0) begin
				req_valid <= 0;
			end else begin
				req_valid <= 1;
				action <= cur_beat.op;
				left_operand <= cur_beat.a;
				right_operand <= cur_beat.b;
				holding = 0;
			end
		end
	end

	// result receiver, with one long hold-off to back the pipeline up
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_took && results_seen == HOLD_AT) begin
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1;
			end else begin
				if (rsp_took) begin
					stall_left = ((results_seen / 150) % 2 == 0) ? $urandom_range(0, IDLE_MAX) : 0;
				end
				if (stall_left > 0) begin
					stall_left--;
					rsp_stall <= 1;
				end else begin
					rsp_stall <= 0;
				end
			end
		end
	end

	// monitor: predict on each accepted beat, check each accepted result
	always @(posedge clk) begin : check_beats
		alu_answer_t want;
		if (arst_n) begin
			req_took <= req_valid && !req_stall;
			rsp_took <= rsp_valid && !rsp_stall;
			if (req_valid && !req_stall) begin
				answer_q.push_back(predict_alu(action, left_operand, right_operand));
				beats_sent++;
			end
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (answer_q.size() == 0) begin
					report_mismatch($sformatf("result %05h status %0d with no beat outstanding",
						result, status));
				end else begin
					want = answer_q.pop_front();
					if (want.status == ST_DIV_ZERO) begin
						div_zero_seen++;
					end
					if (want.status == ST_BAD_OP) begin
						bad_op_seen++;
					end
					if (result !== want.result) begin
						report_mismatch($sformatf("action %0d a %05h b %05h: result %05h, want %05h",
							want.op, want.a, want.b, result, want.result));
					end
					if (status !== want.status) begin
						report_mismatch($sformatf("action %0d a %05h b %05h: status %0d, want %0d",
							want.op, want.a, want.b, status, want.status));
					end
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("timeout after %0d idle cycles", idle_cycles);
					$display("ones_complement_18bit_alu: mismatch");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [3:0]        op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;

		// directed corners
		add_beat(ACT_OR, 18'h2AAAA, 18'h15555);
		add_beat(ACT_XOR, NEG_ZERO, '0);
		add_beat(ACT_AND, NEG_ZERO, NEG_ZERO);
		add_beat(ACT_LSHIFT, NEG_ZERO, WORD_W'(SHIFT_LIMIT - 1));
		add_beat(ACT_LSHIFT, 18'd1, WORD_W'(SHIFT_LIMIT));
		add_beat(ACT_RSHIFT, NEG_ZERO, NEG_ZERO);
		add_beat(ACT_RSHIFT, MAX_NEG, WORD_W'(SHIFT_LIMIT - 1));
		add_beat(ACT_CMPL, '0, '0);
		add_beat(ACT_PLUS, MAX_POS, 18'd1);
		add_beat(ACT_PLUS, NEG_ZERO, NEG_ZERO);
		add_beat(ACT_PLUS, 18'd5, ~18'd5);
		add_beat(ACT_MINUS, MAX_NEG, MAX_POS);
		add_beat(ACT_MINUS, '0, NEG_ZERO);
		add_beat(ACT_MUL, MAX_POS, MAX_POS);
		add_beat(ACT_MUL, MAX_NEG, MAX_POS);
		add_beat(ACT_DIV, 18'd7, '0);
		add_beat(ACT_DIV, 18'd7, NEG_ZERO);
		add_beat(ACT_DIV, ~18'd7, 18'd2);
		add_beat(ACT_MOD, ~18'd7, 18'd2);
		add_beat(ACT_MOD, 18'd7, '0);
		add_beat(ACT_MOD, 18'd7, ~18'd2);
		add_beat(ACT_MOD, MAX_NEG, NEG_ZERO);
		add_beat(ACT_NEGATE, NEG_ZERO, '0);
		add_beat(4'(ACT_NEGATE + 1), NEG_ZERO, NEG_ZERO);
		add_beat(ACTION_MAX, MAX_POS, MAX_NEG);

		// random beats, gaps on and off in blocks of a hundred
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			sender_idles = ((i / 100) % 2 == 0);
			if ($urandom_range(0, 99) < 5) begin
				op = 4'($urandom_range(ACT_NEGATE + 1, ACTION_MAX));
			end else begin
				op = 4'($urandom_range(ACT_OR, ACT_NEGATE));
			end
			a = pick_word();
			if ((op == ACT_LSHIFT || op == ACT_RSHIFT) && $urandom_range(0, 3) != 0) begin
				b = WORD_W'($urandom_range(0, SHIFT_LIMIT + 2));
			end else begin
				b = pick_word();
			end
			add_beat(op, a, b, i == 0 || i == 200 || i == 400);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		while (beat_q.size() != 0 || holding || req_valid) begin
			@(posedge clk);
		end
		while (answer_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d beats over all twelve actions and unused codes, checked %0d results",
			beats_sent, results_seen);
		$display("%0d divide-by-zero results, %0d bad-operation results, %0d errors",
			div_zero_seen, bad_op_seen, errors);
		if (errors == 0 && answer_q.size() == 0) begin
			$display("ones_complement_18bit_alu: match");
		end else begin
			$display("ones_complement_18bit_alu: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/oca_pkg.sv
hdl/oca_front.sv
hdl/oca_div_stage.sv
hdl/oca_format.sv
hdl/ones_complement_18bit_alu.sv
verif/testbench.sv
